// ===== sv/rerd_pkg.sv =====
// ============================================================================
// rerd_pkg - shared types and functions for the Rice residual decoder
// Holds the decoder state layout, result layout, register indexes and the
// single-bit decode step used by the bit-pair datapath.
// ============================================================================
package rerd_pkg;

    localparam int MAX_FRAME   = 512;
    localparam int CNT_W       = $clog2(MAX_FRAME);
    localparam int K_W         = 4;
    localparam int CPC_W       = 9;
    localparam int VAL_W       = 32;
    localparam int RAW_W       = 16;
    localparam int LEFT_W      = 5;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PAIR_W      = $clog2(BYTE_W / 2);

    // phase codes
    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_RAW   = 2'd1;
    localparam logic [1:0] PH_UNARY = 2'd2;
    localparam logic [1:0] PH_REM   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_K_MID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K_SIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODES  = 2'd2;

    typedef struct packed {
        logic [1:0]        phase;
        logic              chan;
        logic [VAL_W-1:0]  quot;
        logic [RAW_W-1:0]  acc;
        logic [LEFT_W-1:0] left;
        logic [CNT_W-1:0]  cnt;
    } dec_state_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             escaped;
        logic             channel;
        logic             frame_done;
    } result_t;

    typedef struct packed {
        dec_state_t st;
        logic       emit;
        result_t    res;
    } step_t;

    typedef struct packed {
        logic [K_W-1:0]   k_mid;
        logic [K_W-1:0]   k_side;
        logic [CPC_W-1:0] codes;
    } cfg_t;

    // zigzag unfold: (u >> 1) ^ -(u & 1)
    function automatic logic [VAL_W-1:0] unfold(logic [VAL_W-1:0] u);
        return {1'b0, u[VAL_W-1:1]} ^ {VAL_W{u[0]}};
    endfunction

    // Consume one stream bit.
    function automatic step_t bit_step(dec_state_t s, logic b, cfg_t cfg);
        step_t             r;
        logic [K_W-1:0]    k;
        logic [RAW_W-1:0]  acc_n;
        logic [LEFT_W-1:0] left_n;
        logic [VAL_W-1:0]  qsh;
        logic [CNT_W-1:0]  nxt;
        logic              last;
        logic              fin;
        logic [VAL_W-1:0]  val;
        logic              esc;
        r      = '0;
        r.st   = s;
        fin    = 1'b0;
        val    = '0;
        esc    = 1'b0;
        k      = s.chan ? cfg.k_side : cfg.k_mid;
        acc_n  = {s.acc[RAW_W-2:0], b};
        left_n = s.left - LEFT_W'(1);
        qsh    = s.quot << k;
        nxt    = s.cnt + CNT_W'(1);
        last   = (nxt == cfg.codes[CNT_W-1:0]);
        unique case (s.phase)
            PH_FLAG:
            begin
                r.st.acc = '0;
                if (b)
                begin
                    r.st.phase = PH_RAW;
                    r.st.left  = LEFT_W'(RAW_W);
                end
                else
                begin
                    r.st.phase = PH_UNARY;
                    r.st.quot  = '0;
                end
            end
            PH_RAW:
            begin
                r.st.acc  = acc_n;
                r.st.left = left_n;
                if (left_n == '0)
                begin
                    fin = 1'b1;
                    esc = 1'b1;
                    val = {{(VAL_W-RAW_W){acc_n[RAW_W-1]}}, acc_n};
                end
            end
            PH_UNARY:
            begin
                if (b)
                begin
                    r.st.quot = s.quot + VAL_W'(1);
                end
                else
                begin
                    r.st.quot = qsh;
                    if (k == '0)
                    begin
                        fin = 1'b1;
                        val = unfold(qsh);
                    end
                    else
                    begin
                        r.st.phase = PH_REM;
                        r.st.left  = LEFT_W'(k);
                        r.st.acc   = '0;
                    end
                end
            end
            PH_REM:
            begin
                r.st.acc  = acc_n;
                r.st.left = left_n;
                if (left_n == '0)
                begin
                    fin = 1'b1;
                    val = unfold(s.quot + VAL_W'(acc_n));
                end
            end
        endcase
        if (fin)
        begin
            r.emit           = 1'b1;
            r.res.value      = val;
            r.res.escaped    = esc;
            r.res.channel    = s.chan;
            r.res.frame_done = last & s.chan;
            r.st.phase       = PH_FLAG;
            r.st.left        = '0;
            r.st.acc         = '0;
            r.st.cnt         = last ? '0 : nxt;
            r.st.chan        = last ? ~s.chan : s.chan;
        end
        return r;
    endfunction

endpackage

// ===== sv/rerd_byte_queue.sv =====
// ============================================================================
// rerd_byte_queue - input byte queue
// Accepts stream bytes and holds them for the decoder, so the stream side
// keeps moving while the decoder works through a byte or waits on output.
// ============================================================================
module rerd_byte_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      stream_valid,
    output logic                      stream_ready,
    input  logic [rerd_pkg::BYTE_W-1:0] stream_byte,
    output logic                      head_valid,
    output logic [rerd_pkg::BYTE_W-1:0] head_byte,
    input  logic                      pop
);
    import rerd_pkg::*;

    logic [BYTE_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pull;

    assign stream_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid   = (count_reg != '0);
    assign head_byte    = mem_reg[rd_ptr_reg];
    assign push         = stream_valid & stream_ready;
    assign pull         = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (pull)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pull)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pull && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= stream_byte;
        end
    end

endmodule

// ===== sv/rerd_decoder.sv =====
// ============================================================================
// rerd_decoder - bit-pair code decoder and result stage
// Walks the head byte two bits per cycle unless stalled, holds each finished
// code until it is known whether it is the last of its byte, then hands it
// to the output register.
// ============================================================================
module rerd_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rerd_pkg::cfg_t              cfg,
    input  logic                        head_valid,
    input  logic [rerd_pkg::BYTE_W-1:0] head_byte,
    output logic                        pop,
    output logic                        result_valid,
    input  logic                        result_ready,
    output rerd_pkg::result_t           result,
    output logic                        result_last
);
    import rerd_pkg::*;

    dec_state_t          st_reg;
    dec_state_t          st_next;
    logic [PAIR_W-1:0]   pair_reg;
    logic [PAIR_W-1:0]   pair_next;
    logic                pend_vld_reg;
    logic                pend_vld_next;
    logic                pend_closed_reg;
    logic                pend_closed_next;
    result_t             pend_reg;
    result_t             pend_next;
    logic                out_vld_reg;
    logic                out_vld_next;
    logic                out_last_reg;
    result_t             out_reg;

    logic [BYTE_W-1:0]   shifted;
    step_t               s1;
    step_t               s2;
    logic                emit;
    result_t             res;
    logic                done;
    logic                eob;
    logic                push;
    logic                out_free;
    logic                stall;
    logic                do_step;

    // current bit pair sits at the top of the shifted byte
    assign shifted = head_byte << {pair_reg, 1'b0};
    assign s1      = bit_step(st_reg, shifted[BYTE_W-1], cfg);
    assign s2      = bit_step(s1.st, shifted[BYTE_W-2], cfg);

    always_comb
    begin
        done = s1.emit & s1.res.frame_done;
        emit = s1.emit | (!done & s2.emit);
        res  = s1.emit ? s1.res : s2.res;
        if (!done)
        begin
            done = s2.emit & s2.res.frame_done;
        end
    end

    assign eob      = (pair_reg == PAIR_W'(BYTE_W / 2 - 1)) | done;
    assign push     = pend_vld_reg & (pend_closed_reg | (head_valid & emit));
    assign out_free = !out_vld_reg | result_ready;
    assign stall    = push & !out_free;
    assign do_step  = head_valid & !stall;
    assign pop      = do_step & eob;

    always_comb
    begin
        st_next          = st_reg;
        pair_next        = pair_reg;
        pend_vld_next    = pend_vld_reg;
        pend_closed_next = pend_closed_reg;
        pend_next        = pend_reg;
        out_vld_next     = out_vld_reg & !result_ready;
        if (push && out_free)
        begin
            out_vld_next  = 1'b1;
            pend_vld_next = 1'b0;
        end
        if (do_step)
        begin
            // a frame end drops the rest of the byte
            st_next   = (s1.emit && s1.res.frame_done) ? s1.st : s2.st;
            pair_next = eob ? '0 : pair_reg + PAIR_W'(1);
            if (emit)
            begin
                pend_vld_next    = 1'b1;
                pend_closed_next = eob;
                pend_next        = res;
            end
            else if (eob)
            begin
                pend_closed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= '0;
            pair_reg        <= '0;
            pend_vld_reg    <= 1'b0;
            pend_closed_reg <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            st_reg          <= st_next;
            pair_reg        <= pair_next;
            pend_vld_reg    <= pend_vld_next;
            pend_closed_reg <= pend_closed_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (push && out_free)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= pend_closed_reg;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;
    assign result_last  = out_last_reg;

endmodule

// ===== sv/rice_escape_residual_decoder.sv =====
// ============================================================================
// rice_escape_residual_decoder - Rice residual decoder with per-code escape
// Decodes the mid and side residual codes of one frame from a byte stream.
// ============================================================================
// Usage:
//   stream channel (stream_valid/stream_ready/stream_byte) takes the residual
//   bitstream one byte per transfer, MSB first, into a two-byte queue.
//   result channel (result_valid/result_ready plus value, escaped, channel,
//   frame_done, last_of_byte) moves one decoded code per transfer.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes rice_k_mid,
//   rice_k_side and codes_per_channel; cfg_ready is always high. Write only
//   while no byte is in flight.
//   The decoder consumes two stream bits per cycle unless stalled by the
//   output; a byte yields at most four results, one per cycle unless stalled.
//   A result waits in a holding stage until its byte is finished or a later
//   code of the same byte completes, then moves to the output register.
//   Reset clears the queue, the decode state (mid channel, expecting an
//   escape flag) and the registers to k = 0 and one code per channel.
//   When result_ready is low the output register holds, the holding stage
//   and decoder stall, and the queue fills and drops stream_ready.
// ============================================================================
module rice_escape_residual_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            stream_valid,
    output logic                            stream_ready,
    input  logic [rerd_pkg::BYTE_W-1:0]     stream_byte,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic signed [rerd_pkg::VAL_W-1:0] value,
    output logic                            escaped,
    output logic                            channel,
    output logic                            frame_done,
    output logic                            last_of_byte,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rerd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rerd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rerd_pkg::*;

    cfg_t              cfg_reg;
    logic              head_valid;
    logic [BYTE_W-1:0] head_byte;
    logic              pop;
    result_t           result;
    logic              result_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.k_mid  <= '0;
            cfg_reg.k_side <= '0;
            cfg_reg.codes  <= CPC_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_K_MID:  cfg_reg.k_mid  <= cfg_data[K_W-1:0];
                CFG_K_SIDE: cfg_reg.k_side <= cfg_data[K_W-1:0];
                CFG_CODES:  cfg_reg.codes  <= cfg_data[CPC_W-1:0];
                default:    ;
            endcase
        end
    end

    rerd_byte_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_ready (stream_ready),
        .stream_byte  (stream_byte),
        .head_valid   (head_valid),
        .head_byte    (head_byte),
        .pop          (pop)
    );

    rerd_decoder u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_byte    (head_byte),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .result_last  (result_last)
    );

    assign value        = result.value;
    assign escaped      = result.escaped;
    assign channel      = result.channel;
    assign frame_done   = result.frame_done;
    assign last_of_byte = result_last;

`ifndef ASSERT_OFF
    // the frame ends on a side code, and drops the rest of its byte
    a_done_side: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_done |-> channel)
        else $error("frame end on a mid code");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_done |-> last_of_byte)
        else $error("frame end not closing its byte");

    // raw samples are 16-bit sign-extended
    a_raw_sext: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && escaped |->
            (value[VAL_W-1:RAW_W-1] == '0) || (value[VAL_W-1:RAW_W-1] == '1))
        else $error("escaped sample not sign-extended");
`endif

endmodule
